/* src/cdsd_pkg.sv */
// Shared types and constants for the capture dump sample decoder.
// No dependencies; every other source file but cdsd_check imports this package.
package cdsd_pkg;

  // Samples in one dump and the width of the sample counter.
  localparam int SAMPLES_PER_DUMP = 1024;
  localparam int IDX_W            = (SAMPLES_PER_DUMP > 1) ? $clog2(SAMPLES_PER_DUMP) : 1;
  localparam int LAST_IDX         = SAMPLES_PER_DUMP - 1;

  // Configuration port layout and register indexes.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_NEG = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_IDX = 4'd3;

  localparam logic [23:0]        GAIN_RST     = 24'd72000;
  localparam logic signed [31:0] OFFSET_RST   = 32'sd0;
  localparam logic               TRIG_NEG_RST = 1'b1;
  localparam logic [10:0]        TRIG_IDX_RST = 11'd0;

  // Converter midscale and the Q.24 to Q16.16 rounding bias.
  localparam logic signed [10:0] RAW_MID    = 11'sd512;
  localparam logic signed [35:0] ROUND_BIAS = 36'sd128;

  typedef struct packed {
    logic [23:0]        gain;
    logic signed [31:0] offset;
    logic               trig_neg;
    logic [10:0]        trig_idx;
  } cfg_t;

  typedef struct packed {
    logic [9:0] raw;
    logic [7:0] levels;
    logic       here;
    logic       after;
    logic       last;
  } sample_t;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_THIRD  = 3'b100
  } phase_t;

endpackage

/* src/cdsd_cfg_regs.sv */
// Configuration register file for the capture dump sample decoder.
// Depends on cdsd_pkg for the register indexes, reset values and cfg_t.
module cdsd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cdsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cdsd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output cdsd_pkg::cfg_t                   cfg
);
  import cdsd_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GAIN:     cfg_nxt.gain     = cfg_data[23:0];
        CFG_OFFSET:   cfg_nxt.offset   = $signed(cfg_data[31:0]);
        CFG_TRIG_NEG: cfg_nxt.trig_neg = cfg_data[0];
        CFG_TRIG_IDX: cfg_nxt.trig_idx = cfg_data[10:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain     <= GAIN_RST;
      cfg_r.offset   <= OFFSET_RST;
      cfg_r.trig_neg <= TRIG_NEG_RST;
      cfg_r.trig_idx <= TRIG_IDX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* src/cdsd_assemble.sv */
// Byte grouping stage: collects three dump bytes, builds the converter code
// and logic levels, and tracks the sample counter. Depends on cdsd_pkg.
module cdsd_assemble (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  cdsd_pkg::cfg_t    cfg,
  output logic              smp_valid,
  input  logic              smp_ready,
  output cdsd_pkg::sample_t smp
);
  import cdsd_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       byte0_r;
  logic [7:0]       byte1_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  sample_t          smp_r, smp_nxt;
  logic             smp_valid_r, smp_valid_nxt;
  logic             accept;
  logic             last;

  // The sample register may load when it is empty or being drained.
  assign in_ready  = !smp_valid_r || smp_ready;
  assign accept    = in_valid && in_ready;
  assign smp_valid = smp_valid_r;
  assign smp       = smp_r;

  assign last = (idx_r == IDX_W'(LAST_IDX));

  always_comb begin
    smp_nxt.raw    = {byte1_r[3:0], byte0_r[5:0]};
    smp_nxt.levels = {in_byte[5:0], byte1_r[5:4]};
    smp_nxt.last   = last;
    smp_nxt.here   = !cfg.trig_neg && (32'(cfg.trig_idx) == 32'(idx_r));
    smp_nxt.after  = !cfg.trig_neg && last &&
                     (32'(cfg.trig_idx) == 32'(SAMPLES_PER_DUMP));
  end

  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    smp_valid_nxt = smp_valid_r && !smp_ready;
    unique case (phase_r)
      PH_SECOND: begin
        if (accept) phase_nxt = PH_THIRD;
      end
      PH_THIRD: begin
        if (accept) begin
          phase_nxt     = PH_FIRST;
          smp_valid_nxt = 1'b1;
          idx_nxt       = last ? '0 : idx_r + 1'b1;
        end
      end
      PH_FIRST: begin
        if (accept) phase_nxt = PH_SECOND;
      end
      default: begin
        if (accept) phase_nxt = PH_SECOND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      idx_r       <= '0;
      smp_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      smp_valid_r <= smp_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase_r != PH_SECOND && phase_r != PH_THIRD) byte0_r <= in_byte;
    if (accept && phase_r == PH_SECOND) byte1_r <= in_byte;
    if (accept && phase_r == PH_THIRD) smp_r <= smp_nxt;
  end

endmodule

/* src/cdsd_scale.sv */
// Voltage scaling: a multiply stage followed by the rounding, offset and
// saturation stage that feeds the output register. Depends on cdsd_pkg.
module cdsd_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               smp_valid,
  output logic               smp_ready,
  input  cdsd_pkg::sample_t  smp,
  input  cdsd_pkg::cfg_t     cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         out_raw_analog,
  output logic [7:0]         out_logic_bits,
  output logic signed [31:0] out_volts_q16,
  output logic               out_trigger_here,
  output logic               out_trigger_after,
  output logic               out_last_of_dump
);
  import cdsd_pkg::*;

  logic               mul_en, out_en;
  logic               mul_valid_r, mul_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  sample_t            mul_smp_r;
  sample_t            out_smp_r;
  logic signed [10:0] diff;
  logic signed [24:0] gain_s;
  logic signed [35:0] prod_c;
  logic signed [35:0] prod_r;
  logic signed [35:0] rnd_sum;
  logic signed [27:0] q16;
  logic signed [33:0] volts_wide;
  logic signed [31:0] volts_nxt;
  logic signed [31:0] volts_r;

  assign out_en    = !out_valid_r || out_ready;
  assign mul_en    = !mul_valid_r || out_en;
  assign smp_ready = mul_en;

  // (512 - raw) * gain is below 2^34 in magnitude, so 36 bits hold it.
  assign diff   = RAW_MID - $signed({1'b0, smp.raw});
  assign gain_s = $signed({1'b0, cfg.gain});
  assign prod_c = diff * gain_s;

  // Round Q.24 to Q16.16 to nearest with ties upward, subtract the offset
  // and clamp to the signed 32-bit range.
  always_comb begin
    rnd_sum    = prod_r + ROUND_BIAS;
    q16        = rnd_sum[35:8];
    volts_wide = 34'(q16) - 34'(cfg.offset);
    if (volts_wide[33:31] == 3'b000 || volts_wide[33:31] == 3'b111) begin
      volts_nxt = volts_wide[31:0];
    end else if (volts_wide[33]) begin
      volts_nxt = 32'sh8000_0000;
    end else begin
      volts_nxt = 32'sh7fff_ffff;
    end
  end

  assign mul_valid_nxt = mul_en ? smp_valid : mul_valid_r;
  assign out_valid_nxt = out_en ? mul_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= mul_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en && smp_valid) begin
      mul_smp_r <= smp;
      prod_r    <= prod_c;
    end
    if (out_en && mul_valid_r) begin
      out_smp_r <= mul_smp_r;
      volts_r   <= volts_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_raw_analog    = out_smp_r.raw;
  assign out_logic_bits    = out_smp_r.levels;
  assign out_volts_q16     = volts_r;
  assign out_trigger_here  = out_smp_r.here;
  assign out_trigger_after = out_smp_r.after;
  assign out_last_of_dump  = out_smp_r.last;

endmodule

/* src/capture_dump_sample_decoder.sv */
// Top level of the capture dump sample decoder.
// Depends on cdsd_pkg, cdsd_cfg_regs, cdsd_assemble and cdsd_scale.
//
// The decoder takes one dump byte per cycle while in_ready is high and
// delivers one sample beat for every third byte: a 10-bit converter code,
// eight logic levels, a saturated Q16.16 voltage ((512 - code) * gain -
// offset) and the trigger and end-of-dump marks. A sample passes from its
// third byte to the output through the grouping register, the multiply
// register and the output register; the single 11 x 25 bit multiply stage
// sets the clock rate. Registers are written through the cfg channel, which
// is always ready; write them only while no sample is in flight.
module capture_dump_sample_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_dump_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [9:0]                       out_raw_analog,
  output logic [7:0]                       out_logic_bits,
  output logic signed [31:0]               out_volts_q16,
  output logic                             out_trigger_here,
  output logic                             out_trigger_after,
  output logic                             out_last_of_dump,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cdsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cdsd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cdsd_pkg::*;

  cfg_t    cfg;
  sample_t smp;
  logic    smp_valid;
  logic    smp_ready;

  cdsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cdsd_assemble u_assemble (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_dump_byte),
    .cfg       (cfg),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .smp       (smp)
  );

  cdsd_scale u_scale (
    .clk               (clk),
    .rst_n             (rst_n),
    .smp_valid         (smp_valid),
    .smp_ready         (smp_ready),
    .smp               (smp),
    .cfg               (cfg),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_raw_analog    (out_raw_analog),
    .out_logic_bits    (out_logic_bits),
    .out_volts_q16     (out_volts_q16),
    .out_trigger_here  (out_trigger_here),
    .out_trigger_after (out_trigger_after),
    .out_last_of_dump  (out_last_of_dump)
  );

endmodule

/* src/cdsd_check.sv */
// Port-level checks for the capture dump sample decoder, bound to the top.
// Depends only on the top level's handshake and result ports.
module cdsd_check (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [9:0]                       out_raw_analog,
  input logic [7:0]                       out_logic_bits,
  input logic signed [31:0]               out_volts_q16,
  input logic                             out_trigger_here,
  input logic                             out_trigger_after,
  input logic                             out_last_of_dump
);

  // A stalled output beat keeps its sample.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_volts_q16) &&
                                   $stable(out_raw_analog) && $stable(out_logic_bits)))
    else $error("output beat changed while stalled");

  // Input back-pressure only comes from a full pipeline behind a stalled output.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

  // A trigger just past the dump is only flagged on the dump's last sample.
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_trigger_after) |-> out_last_of_dump)
    else $error("trigger_after outside the last sample");

  // One trigger index cannot mark both a sample and the end of the dump.
  a_trig_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_trigger_here && out_trigger_after))
    else $error("trigger_here and trigger_after both set");

endmodule

bind capture_dump_sample_decoder cdsd_check u_check (.*);

/* sim/tb_capture_dump_sample_decoder.sv */
// Self-checking testbench for capture_dump_sample_decoder.
// Depends on cdsd_pkg and the decoder RTL; a scoreboard class predicts every
// sample from the accepted dump bytes and checks the result beats in order.
module tb_capture_dump_sample_decoder;
  import cdsd_pkg::*;

  localparam int     CYCLE_LIMIT    = 500000;
  localparam int     SETTLE_CYCLES  = 6;
  localparam int     TAIL_CYCLES    = 10;
  localparam int     LONG_HOLD      = 300;
  localparam int     TARGET_SAMPLES = 300;
  localparam int     HOLD_PHASE     = 1;
  localparam int     PAUSE_PHASE    = 4;
  localparam int     MAX_PRINTED    = 20;
  localparam int     MIDSCALE       = 512;
  localparam longint VOLT_MAX       = 64'sd2147483647;
  localparam longint VOLT_MIN       = -64'sd2147483648;

  typedef struct packed {
    logic [9:0]         code;
    logic [7:0]         levels;
    logic signed [31:0] volts;
    logic               trig_here;
    logic               trig_after;
    logic               dump_end;
  } decoded_sample_t;

  class sample_scoreboard;
    logic [23:0]        gain;
    logic signed [31:0] offset;
    logic               trig_neg;
    logic [10:0]        trig_idx;
    phase_t             next_byte;
    logic [7:0]         byte0;
    logic [7:0]         byte1;
    logic [IDX_W-1:0]   sample_idx;
    decoded_sample_t    pending_samples[$];
    int errors, samples, dump_ends, here_marks, after_marks, clipped;

    function new();
      gain       = GAIN_RST;
      offset     = OFFSET_RST;
      trig_neg   = TRIG_NEG_RST;
      trig_idx   = TRIG_IDX_RST;
      next_byte  = PH_FIRST;
      byte0      = '0;
      byte1      = '0;
      sample_idx = '0;
      errors = 0; samples = 0; dump_ends = 0; here_marks = 0; after_marks = 0; clipped = 0;
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GAIN:     gain     = data[23:0];
        CFG_OFFSET:   offset   = data;
        CFG_TRIG_NEG: trig_neg = data[0];
        CFG_TRIG_IDX: trig_idx = data[10:0];
        default: ;
      endcase
    endfunction

    // (512 - code) * gain is exact in Q.24; round to Q16.16 with ties upward,
    // subtract the offset and clip to 32 bits.
    function logic signed [31:0] scale_volts(logic [9:0] code);
      longint prod, q16, v;
      prod = (longint'(MIDSCALE) - longint'(code)) * longint'(gain);
      q16  = (prod + 64'sd128) >>> 8;
      v    = q16 - longint'(offset);
      if (v > VOLT_MAX) begin
        v = VOLT_MAX;
        clipped++;
      end else if (v < VOLT_MIN) begin
        v = VOLT_MIN;
        clipped++;
      end
      return v[31:0];
    endfunction

    function void take_byte(logic [7:0] b);
      decoded_sample_t s;
      if (next_byte == PH_SECOND) begin
        byte1     = b;
        next_byte = PH_THIRD;
      end else if (next_byte != PH_THIRD) begin
        byte0     = b;
        next_byte = PH_SECOND;
      end else begin
        next_byte    = PH_FIRST;
        s.code       = {byte1[3:0], byte0[5:0]};
        s.levels     = {b[5:0], byte1[5:4]};
        s.volts      = scale_volts(s.code);
        s.dump_end   = (int'(sample_idx) + 1 >= SAMPLES_PER_DUMP);
        s.trig_here  = !trig_neg && (int'(trig_idx) == int'(sample_idx));
        s.trig_after = !trig_neg && s.dump_end && (int'(trig_idx) == SAMPLES_PER_DUMP);
        sample_idx   = s.dump_end ? '0 : sample_idx + 1'b1;
        pending_samples.push_back(s);
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("MISMATCH: %s", msg);
    endtask

    task match_sample(logic [9:0] code, logic [7:0] levels, logic signed [31:0] volts,
                      logic here, logic after_end, logic dump_end);
      decoded_sample_t want;
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("sample with code %0d arrived with none outstanding", code));
        return;
      end
      want = pending_samples.pop_front();
      if (code !== want.code)
        report_mismatch($sformatf("sample %0d code %0d, want %0d", samples, code, want.code));
      if (levels !== want.levels)
        report_mismatch($sformatf("sample %0d levels %02h, want %02h",
                                  samples, levels, want.levels));
      if (volts !== want.volts)
        report_mismatch($sformatf("sample %0d volts %0d, want %0d",
                                  samples, volts, want.volts));
      if (here !== want.trig_here)
        report_mismatch($sformatf("sample %0d trigger_here %b, want %b",
                                  samples, here, want.trig_here));
      if (after_end !== want.trig_after)
        report_mismatch($sformatf("sample %0d trigger_after %b, want %b",
                                  samples, after_end, want.trig_after));
      if (dump_end !== want.dump_end)
        report_mismatch($sformatf("sample %0d last_of_dump %b, want %b",
                                  samples, dump_end, want.dump_end));
      samples++;
      if (want.dump_end) dump_ends++;
      if (want.trig_here) here_marks++;
      if (want.trig_after) after_marks++;
    endtask

    task close_out();
      if (pending_samples.size() != 0)
        report_mismatch($sformatf("%0d samples never arrived", pending_samples.size()));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_dump_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [9:0]            out_raw_analog;
  logic [7:0]            out_logic_bits;
  logic signed [31:0]    out_volts_q16;
  logic                  out_trigger_here;
  logic                  out_trigger_after;
  logic                  out_last_of_dump;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sample_scoreboard sb;
  logic [7:0]       byte_q[$];
  bit               hold_req = 1'b0;
  int               cycle_count = 0;

  capture_dump_sample_decoder u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_dump_byte      (in_dump_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_raw_analog    (out_raw_analog),
    .out_logic_bits    (out_logic_bits),
    .out_volts_q16     (out_volts_q16),
    .out_trigger_here  (out_trigger_here),
    .out_trigger_after (out_trigger_after),
    .out_last_of_dump  (out_last_of_dump),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.match_sample(out_raw_analog, out_logic_bits, out_volts_q16,
                      out_trigger_here, out_trigger_after, out_last_of_dump);
  end

  // Result side pacing: short stalls, free-running stretches, and one long
  // hold-off on request so the decoder backs up into its input.
  initial begin : out_pacer
    int run_len;
    int hold_cycles;
    bit lvl;
    out_ready <= 1'b0;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < LONG_HOLD) begin
          @(posedge clk);
          hold_cycles++;
        end
        hold_req = 1'b0;
      end else begin
        case ($urandom_range(0, 5))
          0: begin lvl = 1'b1; run_len = $urandom_range(40, 120); end
          1, 2: begin lvl = 1'b0; run_len = $urandom_range(1, 6); end
          default: begin lvl = 1'b1; run_len = $urandom_range(1, 10); end
        endcase
        out_ready <= lvl;
        repeat (run_len) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles", cycle_count);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Sends byte_q, in random bursts unless steady is set. A pause index drops valid
  // and waits until every outstanding sample has come back before going on.
  task automatic drive_stream(int pause_at, bit steady);
    int burst_left;
    int gap;
    burst_left = 0;
    for (int k = 0; k < byte_q.size(); k++) begin
      if (k == pause_at) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end else if (burst_left == 0 && !steady) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_valid     <= 1'b1;
      in_dump_byte <= byte_q[k];
      do @(posedge clk); while (!in_ready);
      sb.take_byte(byte_q[k]);
      if (burst_left > 0) burst_left--;
    end
    in_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int phase_no;
    int planned;
    int n_samples;
    int cur;
    int crossings;
    logic [23:0] gain;
    logic [31:0] offset;
    logic        tneg;
    logic [10:0] tidx;
    sb = new();
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_dump_byte <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed groups at reset settings: code extremes, midscale, unused
    // byte bits set and clear, alternating logic levels.
    byte_q = '{8'h00, 8'h00, 8'h00,  8'h3f, 8'h0f, 8'h00,  8'hff, 8'hff, 8'hff,
               8'hc0, 8'hf0, 8'hc0,  8'h00, 8'h08, 8'h15,  8'h3f, 8'h07, 8'h2a,
               8'h2a, 8'h25, 8'h15,  8'h15, 8'h1a, 8'h2a};
    drive_stream(-1, 1'b1);
    planned   = byte_q.size() / 3;
    phase_no  = 0;
    crossings = 0;

    while (planned < TARGET_SAMPLES) begin
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);

      n_samples = (phase_no == HOLD_PHASE) ? 100 : $urandom_range(20, 50);
      if (n_samples > TARGET_SAMPLES - planned)
        n_samples = TARGET_SAMPLES - planned;
      cur = int'(sb.sample_idx);

      case ($urandom_range(0, 4))
        0: gain = 24'h000000;
        1: gain = 24'hffffff;
        2: gain = GAIN_RST;
        default: gain = 24'($urandom());
      endcase
      case ($urandom_range(0, 4))
        0: offset = 32'h8000_0000;
        1: offset = 32'h7fff_ffff;
        2: offset = '0;
        3: offset = 32'($signed($urandom_range(0, 2097152)) - 1048576);
        default: offset = $urandom();
      endcase
      // The first settings walk the gain and offset extremes.
      if (phase_no == 0) begin gain = 24'hffffff; offset = 32'h8000_0000; end
      if (phase_no == 1) begin gain = 24'hffffff; offset = 32'h7fff_ffff; end
      if (phase_no == 2) begin gain = 24'h000000; offset = 32'h7fff_ffff; end

      // A phase that runs over the end of the dump puts the trigger at the dump
      // length or last sample; others disable it or place it in or past the dump.
      if (cur + n_samples >= SAMPLES_PER_DUMP) begin
        crossings++;
        tneg = 1'b0;
        tidx = (crossings % 2 == 1) ? 11'(SAMPLES_PER_DUMP) : 11'(SAMPLES_PER_DUMP - 1);
      end else begin
        case ($urandom_range(0, 3))
          0: begin tneg = 1'b1; tidx = 11'($urandom_range(0, 2047)); end
          1: begin tneg = 1'b0; tidx = 11'(cur + $urandom_range(0, n_samples - 1)); end
          2: begin tneg = 1'b0; tidx = 11'($urandom_range(SAMPLES_PER_DUMP + 1, 2047)); end
          default: begin tneg = 1'b0; tidx = 11'(SAMPLES_PER_DUMP); end
        endcase
      end

      write_reg(CFG_GAIN, ($urandom() & 32'hff00_0000) | {8'h00, gain});
      write_reg(CFG_OFFSET, offset);
      write_reg(CFG_TRIG_NEG, ($urandom() & 32'hffff_fffe) | {31'd0, tneg});
      write_reg(CFG_TRIG_IDX, ($urandom() & 32'hffff_f800) | {21'd0, tidx});
      if (phase_no == 0)
        write_reg({CFG_IDX_W{1'b1}}, $urandom());
      else if ($urandom_range(0, 1) == 0)
        write_reg(CFG_IDX_W'(CFG_TRIG_IDX + 1 + $urandom_range(0, 11)), $urandom());
      cfg_valid <= 1'b0;

      byte_q.delete();
      repeat (3 * n_samples) byte_q.push_back(pick_byte());
      if (phase_no == HOLD_PHASE) hold_req = 1'b1;
      drive_stream((phase_no == PAUSE_PHASE) ? (3 * n_samples) / 2 + 1 : -1,
                   (phase_no % 5 == 3));
      planned += n_samples;
      phase_no++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.close_out();
    $display("Checked %0d samples over %0d register settings: %0d dump ends, %0d trigger marks,",
             sb.samples, phase_no + 1, sb.dump_ends, sb.here_marks);
    $display("%0d trigger-after marks and %0d clipped voltages; %0d mismatches.",
             sb.after_marks, sb.clipped, sb.errors);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
